// ===== hw/rtl/dnsax_pkg.sv =====
package dnsax_pkg;

   // payload widths
   localparam int unsigned MSG_BYTE_W  = 8;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned RCODE_W     = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_TYPE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_CLASS = 8'd1;

   // register reset values: host address, internet class
   localparam logic [CSR_DATA_W-1:0] WANTED_TYPE_RESET  = 16'h0001;
   localparam logic [CSR_DATA_W-1:0] WANTED_CLASS_RESET = 16'h0001;

   // header and record geometry
   localparam logic [COUNT_W-1:0] HDR_LAST_OFFSET     = 16'd11;
   localparam logic [COUNT_W-1:0] HDR_FLAGS_HI_OFFSET = 16'd2;
   localparam logic [COUNT_W-1:0] HDR_FLAGS_LO_OFFSET = 16'd3;
   localparam logic [COUNT_W-1:0] HDR_QD_HI_OFFSET    = 16'd4;
   localparam logic [COUNT_W-1:0] HDR_QD_LO_OFFSET    = 16'd5;
   localparam logic [COUNT_W-1:0] HDR_AN_HI_OFFSET    = 16'd6;
   localparam logic [COUNT_W-1:0] HDR_AN_LO_OFFSET    = 16'd7;
   localparam logic [COUNT_W-1:0] QTAIL_LAST_OFFSET   = 16'd3;
   localparam logic [COUNT_W-1:0] FIX_TYPE_HI_OFFSET  = 16'd0;
   localparam logic [COUNT_W-1:0] FIX_TYPE_LO_OFFSET  = 16'd1;
   localparam logic [COUNT_W-1:0] FIX_CLASS_HI_OFFSET = 16'd2;
   localparam logic [COUNT_W-1:0] FIX_CLASS_LO_OFFSET = 16'd3;
   localparam logic [COUNT_W-1:0] FIX_LEN_HI_OFFSET   = 16'd8;
   localparam logic [COUNT_W-1:0] FIX_LEN_LO_OFFSET   = 16'd9;
   localparam logic [COUNT_W-1:0] CAPTURE_LAST_OFFSET = 16'd3;
   localparam logic [1:0]         LABEL_POINTER_TAG   = 2'b11;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_FOUND       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONEXISTENT = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OTHER_RCODE = 3'd6;
   localparam logic [RCODE_W-1:0]  RCODE_MAX_MAPPED   = 4'd5;

   typedef enum logic [3:0] {
      PH_HEADER   = 4'd0,
      PH_NAME_LEN = 4'd1,
      PH_NAME_SKP = 4'd2,
      PH_NAME_PTR = 4'd3,
      PH_QTAIL    = 4'd4,
      PH_AFIXED   = 4'd5,
      PH_CAPTURE  = 4'd6,
      PH_RSKIP    = 4'd7,
      PH_DONE     = 4'd8
   } phase_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   ipv4_address;
   } result_type;

endpackage

// ===== hw/rtl/dnsax_if.sv =====
interface dnsax_req_if;
   import dnsax_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MSG_BYTE_W-1:0] msg_byte;
   logic                  last_byte;
   modport source (output valid, output msg_byte, output last_byte, input ready);
   modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

interface dnsax_rsp_if;
   import dnsax_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   ipv4_address;
   modport source (output valid, output status, output ipv4_address, input ready);
   modport sink   (input valid, input status, input ipv4_address, output ready);
endinterface

interface dnsax_csr_if;
   import dnsax_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dns_answer_address_extractor_top.sv =====
// the last byte's result is registered in the output register, or the skid entry
// throughput: one byte per cycle unless stalled, set by the one-pass parse update
// a two-entry result buffer (output register plus skid) keeps input flowing
// while a result waits; input stalls only when both entries are full
// reset (synchronous, active high) returns the parser to the header phase,
// empties the result buffer and sets wanted type and class to 1
module dns_answer_address_extractor_top (
   input logic        clock,
   input logic        reset,
   dnsax_req_if.sink  req_chan,
   dnsax_rsp_if.source rsp_chan,
   dnsax_csr_if.sink  csr_chan
);
   import dnsax_pkg::*;

   logic [CSR_DATA_W-1:0] wanted_type_ff, wanted_class_ff;

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   offset_ff, offset_in;
   logic                 resp_bit_ff, resp_bit_in;
   logic [RCODE_W-1:0]   rcode_ff, rcode_in;
   logic [COUNT_W-1:0]   qd_left_ff, qd_left_in;
   logic [COUNT_W-1:0]   an_left_ff, an_left_in;
   logic [COUNT_W-1:0]   rec_type_ff, rec_type_in;
   logic [COUNT_W-1:0]   rec_class_ff, rec_class_in;
   logic [COUNT_W-1:0]   data_len_ff, data_len_in;
   logic [ADDR_W-1:0]    addr_acc_ff, addr_acc_in;
   logic                 found_ff, found_in;

   logic                 out_valid_ff, skid_valid_ff;
   result_type           out_ff, skid_ff;
   result_type           result;

   logic                 req_take, push, out_free;
   logic [MSG_BYTE_W-1:0] b;
   logic [COUNT_W-1:0]   b_wide, len_new, an_dec, off_dec;

   assign req_chan.ready = !skid_valid_ff;
   assign csr_chan.ready = 1'b1;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign push           = req_take && req_chan.last_byte;
   assign out_free       = !out_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.ipv4_address = out_ff.ipv4_address;

   assign b       = req_chan.msg_byte;
   assign b_wide  = {{(COUNT_W-MSG_BYTE_W){1'b0}}, b};
   assign len_new = data_len_ff | b_wide;
   assign an_dec  = an_left_ff - 16'd1;
   assign off_dec = offset_ff - 16'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff  <= WANTED_TYPE_RESET;
         wanted_class_ff <= WANTED_CLASS_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_WANTED_TYPE:  wanted_type_ff  <= csr_chan.data;
            CSR_WANTED_CLASS: wanted_class_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // per-byte parse step
   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      resp_bit_in  = resp_bit_ff;
      rcode_in     = rcode_ff;
      qd_left_in   = qd_left_ff;
      an_left_in   = an_left_ff;
      rec_type_in  = rec_type_ff;
      rec_class_in = rec_class_ff;
      data_len_in  = data_len_ff;
      addr_acc_in  = addr_acc_ff;
      found_in     = found_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == HDR_FLAGS_HI_OFFSET)      resp_bit_in = b[7];
            else if (offset_ff == HDR_FLAGS_LO_OFFSET) rcode_in = b[RCODE_W-1:0];
            else if (offset_ff == HDR_QD_HI_OFFSET)    qd_left_in = {b, 8'h00};
            else if (offset_ff == HDR_QD_LO_OFFSET)    qd_left_in = qd_left_ff | b_wide;
            else if (offset_ff == HDR_AN_HI_OFFSET)    an_left_in = {b, 8'h00};
            else if (offset_ff == HDR_AN_LO_OFFSET)    an_left_in = an_left_ff | b_wide;
            if (offset_ff >= HDR_LAST_OFFSET) begin
               offset_in = '0;
               if (!resp_bit_ff || rcode_ff != '0 || an_left_ff == '0) phase_in = PH_DONE;
               else phase_in = PH_NAME_LEN;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_NAME_LEN: begin
            if (b[7:6] == LABEL_POINTER_TAG) begin
               phase_in = PH_NAME_PTR;
            end else if (b == '0) begin
               offset_in = '0;
               phase_in  = (qd_left_ff != '0) ? PH_QTAIL : PH_AFIXED;
            end else begin
               offset_in = b_wide;
               phase_in  = PH_NAME_SKP;
            end
         end
         PH_NAME_SKP: begin
            offset_in = off_dec;
            if (off_dec == '0) phase_in = PH_NAME_LEN;
         end
         PH_NAME_PTR: begin
            offset_in = '0;
            phase_in  = (qd_left_ff != '0) ? PH_QTAIL : PH_AFIXED;
         end
         PH_QTAIL: begin
            if (offset_ff >= QTAIL_LAST_OFFSET) begin
               offset_in  = '0;
               qd_left_in = qd_left_ff - 16'd1;
               phase_in   = PH_NAME_LEN;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_AFIXED: begin
            if (offset_ff == FIX_TYPE_HI_OFFSET)       rec_type_in = {b, 8'h00};
            else if (offset_ff == FIX_TYPE_LO_OFFSET)  rec_type_in = rec_type_ff | b_wide;
            else if (offset_ff == FIX_CLASS_HI_OFFSET) rec_class_in = {b, 8'h00};
            else if (offset_ff == FIX_CLASS_LO_OFFSET) rec_class_in = rec_class_ff | b_wide;
            else if (offset_ff == FIX_LEN_HI_OFFSET)   data_len_in = {b, 8'h00};
            else if (offset_ff == FIX_LEN_LO_OFFSET)   data_len_in = len_new;
            if (offset_ff >= FIX_LEN_LO_OFFSET) begin
               offset_in = '0;
               // matching record: capture its address next
               if (rec_type_ff == wanted_type_ff && rec_class_ff == wanted_class_ff) begin
                  addr_acc_in = '0;
                  phase_in    = PH_CAPTURE;
               end else if (len_new == '0) begin
                  an_left_in = an_dec;
                  phase_in   = (an_dec == '0) ? PH_DONE : PH_NAME_LEN;
               end else begin
                  offset_in = len_new;
                  phase_in  = PH_RSKIP;
               end
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_CAPTURE: begin
            addr_acc_in = {addr_acc_ff[ADDR_W-MSG_BYTE_W-1:0], b};
            if (offset_ff >= CAPTURE_LAST_OFFSET) begin
               offset_in = '0;
               found_in  = 1'b1;
               phase_in  = PH_DONE;
            end else begin
               offset_in = offset_ff + 16'd1;
            end
         end
         PH_RSKIP: begin
            offset_in = off_dec;
            if (off_dec == '0) begin
               an_left_in = an_dec;
               offset_in  = '0;
               phase_in   = (an_dec == '0) ? PH_DONE : PH_NAME_LEN;
            end
         end
         default: ;
      endcase
   end

   // status from the state after this byte
   always_comb begin
      result.ipv4_address = '0;
      if (phase_in == PH_HEADER || !resp_bit_in) begin
         result.status = STATUS_NONEXISTENT;
      end else if (rcode_in != '0) begin
         result.status = (rcode_in <= RCODE_MAX_MAPPED) ? rcode_in[STATUS_W-1:0]
                                                        : STATUS_OTHER_RCODE;
      end else if (found_in) begin
         result.status       = STATUS_FOUND;
         result.ipv4_address = addr_acc_in;
      end else begin
         result.status = STATUS_NONEXISTENT;
      end
   end

   // parse state registers, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff     <= PH_HEADER;
         offset_ff    <= '0;
         resp_bit_ff  <= 1'b0;
         rcode_ff     <= '0;
         qd_left_ff   <= '0;
         an_left_ff   <= '0;
         rec_type_ff  <= '0;
         rec_class_ff <= '0;
         data_len_ff  <= '0;
         addr_acc_ff  <= '0;
         found_ff     <= 1'b0;
      end else if (req_take) begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         resp_bit_ff  <= resp_bit_in;
         rcode_ff     <= rcode_in;
         qd_left_ff   <= qd_left_in;
         an_left_ff   <= an_left_in;
         rec_type_ff  <= rec_type_in;
         rec_class_ff <= rec_class_in;
         data_len_ff  <= data_len_in;
         addr_acc_ff  <= addr_acc_in;
         found_ff     <= found_in;
      end
   end

   // result buffer: output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (push) skid_ff <= result;
         end else if (push) begin
            out_ff <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

endmodule

// ===== verif/dns_answer_address_extractor_top_tb.sv =====
module dns_answer_address_extractor_top_tb;
   import dnsax_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam longint TIMEOUT_LIMIT = 2_000_000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 8'hFF;
   localparam logic [15:0] TYPE_HOST  = 16'h0001;
   localparam logic [15:0] TYPE_TEXT  = 16'h0010;
   localparam logic [15:0] CLASS_INET = 16'h0001;
   localparam logic [15:0] CLASS_CHAOS = 16'h0003;
   localparam logic [7:0]  NAME_END   = 8'h00;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dnsax_req_if req_chan ();
   dnsax_rsp_if rsp_chan ();
   dnsax_csr_if csr_chan ();

   dns_answer_address_extractor_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #CLOCK_HALF clock = ~clock;

   // parser copy kept by the testbench
   logic [15:0] want_type;
   logic [15:0] want_class;
   phase_type   parse_ph;
   logic [15:0] pos;
   logic [15:0] quest_left;
   logic [15:0] ans_left;
   logic [15:0] rec_type;
   logic [15:0] rec_class;
   logic [15:0] rd_len;
   logic        seen_qr;
   logic [3:0]  seen_rcode;
   logic [31:0] addr_acc;
   logic        found;

   result_type expected_answers[$];
   logic [7:0] msg_bytes[$];

   int error_count   = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int phase_bytes   = 0;
   int phase_results = 0;

   // ---------------------------------------------------------------- parser
   function automatic void clear_parser();
      parse_ph   = PH_HEADER;
      pos        = '0;
      seen_qr    = 1'b0;
      seen_rcode = '0;
      quest_left = '0;
      ans_left   = '0;
      rec_type   = '0;
      rec_class  = '0;
      rd_len     = '0;
      addr_acc   = '0;
      found      = 1'b0;
   endfunction

   function automatic void finish_name();
      pos      = '0;
      parse_ph = (quest_left != 0) ? PH_QTAIL : PH_AFIXED;
   endfunction

   function automatic void finish_record();
      ans_left = ans_left - 16'd1;
      pos      = '0;
      parse_ph = (ans_left == 0) ? PH_DONE : PH_NAME_LEN;
   endfunction

   function automatic void parse_message_byte(input logic [7:0] b);
      case (parse_ph)
         PH_HEADER: begin
            if (pos == HDR_FLAGS_HI_OFFSET) seen_qr = b[7];
            else if (pos == HDR_FLAGS_LO_OFFSET) seen_rcode = b[3:0];
            else if (pos == HDR_QD_HI_OFFSET) quest_left = {b, 8'h00};
            else if (pos == HDR_QD_LO_OFFSET) quest_left = quest_left | {8'h00, b};
            else if (pos == HDR_AN_HI_OFFSET) ans_left = {b, 8'h00};
            else if (pos == HDR_AN_LO_OFFSET) ans_left = ans_left | {8'h00, b};
            if (pos >= HDR_LAST_OFFSET) begin
               pos = '0;
               if (!seen_qr || seen_rcode != 0 || ans_left == 0) parse_ph = PH_DONE;
               else parse_ph = PH_NAME_LEN;
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_NAME_LEN: begin
            if (b[7:6] == LABEL_POINTER_TAG) parse_ph = PH_NAME_PTR;
            else if (b == NAME_END) finish_name();
            else begin
               pos      = {8'h00, b};
               parse_ph = PH_NAME_SKP;
            end
         end
         PH_NAME_SKP: begin
            pos = pos - 16'd1;
            if (pos == 0) parse_ph = PH_NAME_LEN;
         end
         PH_NAME_PTR: finish_name();
         PH_QTAIL: begin
            if (pos >= QTAIL_LAST_OFFSET) begin
               pos        = '0;
               quest_left = quest_left - 16'd1;
               parse_ph   = PH_NAME_LEN;
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_AFIXED: begin
            if (pos == FIX_TYPE_HI_OFFSET) rec_type = {b, 8'h00};
            else if (pos == FIX_TYPE_LO_OFFSET) rec_type = rec_type | {8'h00, b};
            else if (pos == FIX_CLASS_HI_OFFSET) rec_class = {b, 8'h00};
            else if (pos == FIX_CLASS_LO_OFFSET) rec_class = rec_class | {8'h00, b};
            else if (pos == FIX_LEN_HI_OFFSET) rd_len = {b, 8'h00};
            else if (pos == FIX_LEN_LO_OFFSET) rd_len = rd_len | {8'h00, b};
            if (pos >= FIX_LEN_LO_OFFSET) begin
               pos = '0;
               if (rec_type == want_type && rec_class == want_class) begin
                  addr_acc = '0;
                  parse_ph = PH_CAPTURE;
               end else if (rd_len == 0) begin
                  finish_record();
               end else begin
                  pos      = rd_len;
                  parse_ph = PH_RSKIP;
               end
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_CAPTURE: begin
            addr_acc = {addr_acc[23:0], b};
            if (pos >= CAPTURE_LAST_OFFSET) begin
               pos      = '0;
               found    = 1'b1;
               parse_ph = PH_DONE;
            end else begin
               pos = pos + 16'd1;
            end
         end
         PH_RSKIP: begin
            pos = pos - 16'd1;
            if (pos == 0) finish_record();
         end
         default: ;
      endcase
   endfunction

   // last byte: derive the status and queue the expected answer
   function automatic void close_message();
      result_type r;
      r.ipv4_address = '0;
      if (parse_ph == PH_HEADER || !seen_qr) begin
         r.status = STATUS_NONEXISTENT;
      end else if (seen_rcode != 0) begin
         r.status = (seen_rcode <= RCODE_MAX_MAPPED) ? seen_rcode[STATUS_W-1:0]
                                                     : STATUS_OTHER_RCODE;
      end else if (found) begin
         r.status       = STATUS_FOUND;
         r.ipv4_address = addr_acc;
      end else begin
         r.status = STATUS_NONEXISTENT;
      end
      expected_answers.push_back(r);
      clear_parser();
   endfunction

   // ---------------------------------------------------------------- message building
   function automatic void push_word(input logic [15:0] w);
      msg_bytes.push_back(w[15:8]);
      msg_bytes.push_back(w[7:0]);
   endfunction

   function automatic void push_header(input logic qr, input logic [3:0] rc,
                                       input logic [15:0] qd, input logic [15:0] an);
      push_word(16'($urandom));
      msg_bytes.push_back({qr, 7'($urandom)});
      msg_bytes.push_back({4'($urandom), rc});
      push_word(qd);
      push_word(an);
      push_word(16'($urandom));
      push_word(16'($urandom));
   endfunction

   function automatic void push_label(input int unsigned len);
      msg_bytes.push_back(8'(len));
      repeat (len) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void push_pointer();
      msg_bytes.push_back({LABEL_POINTER_TAG, 6'($urandom)});
      msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void push_tail();
      push_word(16'($urandom));
      push_word(16'($urandom));
   endfunction

   function automatic void push_record(input logic [15:0] t, input logic [15:0] c,
                                       input int unsigned rdlen);
      push_word(t);
      push_word(c);
      push_word(16'($urandom));
      push_word(16'($urandom));
      push_word(16'(rdlen));
      repeat (rdlen) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void trim_message(input int unsigned len);
      while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
   endfunction

   function automatic void push_random_name();
      int unsigned shape = $urandom_range(9);
      int unsigned labels = $urandom_range(1, 2);
      if (shape < 3) begin
         push_pointer();
      end else if (shape == 3) begin
         msg_bytes.push_back(NAME_END);
      end else begin
         repeat (labels)
            push_label(($urandom_range(19) == 0) ? $urandom_range(60, 191)
                                                  : $urandom_range(1, 6));
         if ($urandom_range(1) != 0) push_pointer();
         else msg_bytes.push_back(NAME_END);
      end
   endfunction

   // record whose type and class hit, nearly hit or miss the wanted pair
   function automatic void push_random_record();
      int unsigned pick = $urandom_range(9);
      logic [15:0] flip = 16'd1 << $urandom_range(15);
      logic [15:0] t = 16'($urandom);
      logic [15:0] c = 16'($urandom);
      logic        hit = 1'b0;
      int unsigned rdlen;
      if (pick < 4) begin
         t   = want_type;
         c   = want_class;
         hit = 1'b1;
      end else if (pick < 6) begin
         t = want_type;
         c = want_class ^ flip;
      end else if (pick == 6) begin
         t = want_type ^ flip;
         c = want_class;
      end
      if (hit && $urandom_range(4) != 0) rdlen = 4;
      else if ($urandom_range(9) == 0) rdlen = $urandom_range(7, 40);
      else rdlen = $urandom_range(0, 6);
      push_record(t, c, rdlen);
   endfunction

   function automatic void gen_random_message();
      logic        qr;
      logic [3:0]  rc;
      int unsigned nq;
      int unsigned na;
      logic [15:0] qd_field;
      logic [15:0] an_field;
      msg_bytes.delete();
      if ($urandom_range(99) < 25) begin
         // short noise
         repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom));
      end else begin
         qr       = ($urandom_range(9) != 0);
         rc       = ($urandom_range(9) < 8) ? 4'h0 : 4'($urandom_range(1, 15));
         nq       = $urandom_range(0, 1);
         na       = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2);
         qd_field = ($urandom_range(19) == 0) ? 16'($urandom) : 16'(nq);
         an_field = ($urandom_range(19) == 0) ? 16'($urandom) : 16'(na);
         push_header(qr, rc, qd_field, an_field);
         repeat (nq) begin
            push_random_name();
            push_tail();
         end
         repeat (na) begin
            push_random_name();
            push_random_record();
         end
         repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
         if ($urandom_range(99) < 15) trim_message($urandom_range(1, msg_bytes.size()));
      end
   endfunction

   // one question, a text record to skip, then a host address record
   function automatic void build_sample_response();
      msg_bytes.delete();
      push_header(1'b1, 4'h0, 16'd1, 16'd2);
      push_label(3);
      msg_bytes.push_back(NAME_END);
      push_tail();
      push_pointer();
      push_record(TYPE_TEXT, CLASS_INET, 3);
      push_pointer();
      push_record(TYPE_HOST, CLASS_INET, 4);
   endfunction

   // near miss on the type first, then an exact hit
   function automatic void build_config_probe(input logic [15:0] t, input logic [15:0] c);
      msg_bytes.delete();
      push_header(1'b1, 4'h0, 16'd0, 16'd2);
      push_pointer();
      push_record(t ^ 16'h8001, c, 2);
      push_pointer();
      push_record(t, c, 4);
   endfunction

   function automatic logic [15:0] pick_wanted();
      return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.msg_byte  <= b;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      parse_message_byte(b);
      phase_bytes++;
      if (last) begin
         close_message();
         phase_results++;
      end
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   // drain every pending answer, then let the pipeline settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_WANTED_TYPE:  want_type  = val;
         CSR_WANTED_CLASS: want_class = val;
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [15:0] t, input logic [15:0] c,
                                    input logic poke_unused);
      wait_idle();
      write_register(CSR_WANTED_TYPE, t);
      write_register(CSR_WANTED_CLASS, c);
      if (poke_unused) write_register(CSR_UNUSED_INDEX, 16'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- result checking
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_answers.size() == 0) begin
            error_count++;
            $display("%0t unexpected result: expected none actual status %0d address %h",
                     $time, rsp_chan.status, rsp_chan.ipv4_address);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_chan.status !== want.status) begin
               error_count++;
               $display("%0t status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_chan.status);
            end
            if (rsp_chan.ipv4_address !== want.ipv4_address) begin
               error_count++;
               $display("%0t address mismatch: expected %h actual %h",
                        $time, want.ipv4_address, rsp_chan.ipv4_address);
            end
         end
      end
   end

   // result side ready, with a counted hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reset_registers();
      build_sample_response();
      send_message();
      // trailing bytes after the match are ignored
      build_sample_response();
      repeat (3) msg_bytes.push_back(8'($urandom));
      send_message();
   endtask

   task automatic test_header_rejects();
      logic [3:0] rcodes[7] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd15};
      // response bit clear
      msg_bytes.delete();
      push_header(1'b0, 4'h0, 16'd1, 16'd1);
      push_label(3);
      msg_bytes.push_back(NAME_END);
      push_tail();
      send_message();
      // nonzero rcodes
      foreach (rcodes[i]) begin
         msg_bytes.delete();
         push_header(1'b1, rcodes[i], 16'd0, 16'd1);
         push_word(16'($urandom));
         send_message();
      end
      // no answers
      msg_bytes.delete();
      push_header(1'b1, 4'h0, 16'd1, 16'd0);
      push_pointer();
      push_tail();
      send_message();
   endtask

   // long labels, pointer ends, root name and a zero length record
   task automatic test_name_forms();
      msg_bytes.delete();
      push_header(1'b1, 4'h0, 16'd2, 16'd2);
      push_label(1);
      push_label(64);
      msg_bytes.push_back(NAME_END);
      push_tail();
      push_label(191);
      push_pointer();
      push_tail();
      msg_bytes.push_back(NAME_END);
      push_record(TYPE_TEXT, CLASS_INET, 0);
      push_pointer();
      push_record(TYPE_HOST, CLASS_INET, 4);
      send_message();
   endtask

   task automatic test_no_match();
      msg_bytes.delete();
      push_header(1'b1, 4'h0, 16'd0, 16'd3);
      push_pointer();
      push_record(TYPE_HOST, CLASS_CHAOS, 2);
      push_pointer();
      push_record(TYPE_TEXT, CLASS_INET, 0);
      push_pointer();
      push_record(16'hFFFF, 16'hFFFF, 1);
      repeat (4) msg_bytes.push_back(8'($urandom));
      send_message();
   endtask

   // message cut inside header, name, tail, pointer, fixed part, skip, capture
   task automatic test_early_end();
      int cuts[11] = '{1, 6, 12, 15, 17, 19, 22, 28, 34, 40, 50};
      foreach (cuts[i]) begin
         build_sample_response();
         trim_message(cuts[i]);
         send_message();
      end
   endtask

   task automatic test_config_extremes();
      program_registers(16'h0000, 16'h0000, 1'b0);
      build_config_probe(16'h0000, 16'h0000);
      send_message();
      program_registers(16'hFFFF, 16'hFFFF, 1'b0);
      build_config_probe(16'hFFFF, 16'hFFFF);
      send_message();
      program_registers(16'hAAAA, 16'h5555, 1'b0);
      build_config_probe(16'hAAAA, 16'h5555);
      send_message();
      // an unused index leaves both registers alone
      program_registers(16'h5555, 16'hAAAA, 1'b1);
      build_config_probe(16'h5555, 16'hAAAA);
      send_message();
      program_registers(WANTED_TYPE_RESET, WANTED_CLASS_RESET, 1'b0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int min_bytes, input int min_results);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      phase_bytes   = 0;
      phase_results = 0;
      while (phase_bytes < min_bytes || phase_results < min_results) begin
         gen_random_message();
         send_message();
      end
      wait_idle();
   endtask

   // receiver holds off while short messages keep coming
   task automatic test_result_backpressure();
      wait_idle();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_left     = HOLD_OFF_CYCLES;
      repeat (12) begin
         msg_bytes.delete();
         if ($urandom_range(1) != 0) msg_bytes.push_back(8'($urandom));
         else push_header(1'b1, 4'($urandom_range(1, 15)), 16'd0, 16'd0);
         send_message();
      end
      wait_idle();
   endtask

   // sender stops until all answers are back, then resumes
   task automatic test_drain_pause();
      req_idle_pct  = 29;
      rsp_stall_pct = 29;
      repeat (2) begin
         gen_random_message();
         send_message();
         wait_idle();
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      req_chan.valid     = 1'b0;
      req_chan.msg_byte  = '0;
      req_chan.last_byte = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      want_type  = WANTED_TYPE_RESET;
      want_class = WANTED_CLASS_RESET;
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_registers();
      test_header_rejects();
      test_name_forms();
      test_no_match();
      test_early_end();
      test_config_extremes();

      test_random_traffic(0, 0, 20, 1);
      program_registers(pick_wanted(), pick_wanted(), 1'b0);
      test_random_traffic(80, 0, 20, 1);
      program_registers(pick_wanted(), pick_wanted(), 1'b0);
      test_random_traffic(0, 80, 20, 1);
      program_registers(pick_wanted(), pick_wanted(), 1'b0);
      test_random_traffic(29, 29, 20, 1);

      test_result_backpressure();
      test_drain_pause();

      wait_idle();
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== dns_answer_address_extractor_top.f =====
hw/rtl/dnsax_pkg.sv
hw/rtl/dnsax_if.sv
hw/rtl/dns_answer_address_extractor_top.sv
verif/dns_answer_address_extractor_top_tb.sv
